/* src/ght_pkg.sv */
// Package for the generational handle table: sizes, codes, item types.
// Used by generational_handle_table; depends on nothing.
package ght_pkg;

  // Table geometry
  localparam int SLOT_COUNT   = 256;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_AW      = $clog2(SLOT_COUNT);
  localparam int CNT_W        = SLOT_AW + 1;
  localparam int TAG_W        = 32;
  localparam int ENTRY_W      = PAYLOAD_BITS + TAG_W;

  // Request codes
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_RETIRE   = 2'd1;
  localparam logic [1:0] REQ_RESOLVE  = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;

  // Sequencer states
  typedef enum logic {
    SEQ_IDLE,
    SEQ_EXEC
  } seq_state_t;

  // Input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] payload;
    logic [15:0] handle_index;
    logic [31:0] handle_generation;
  } ght_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [31:0] slot_generation;
    logic [31:0] found_payload;
  } ght_out_t;

endpackage

/* src/ght_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/generational_handle_table.sv */
// Top level of the generational handle table: sequencer, slot RAM, free stack RAM.
// Depends on ght_pkg and ght_ram.
//
// Usage:
//   An item is accepted at a rising edge with start high and busy low. It
//   carries a request (register, retire, resolve) with payload and handle.
//   Each item gives exactly one result item on out_item, marked by out_valid
//   for one cycle; the receiver cannot stall, so results are never held.
//   On accept the item is registered and the slot entry and the free stack
//   top are read from their RAMs, which register the read data; in the
//   execute state the handle is checked, the RAMs are written back and the
//   result is registered onto out_item. A new item is taken only after the
//   last one is through: busy covers the execute state, so no read can
//   overlap a write to the same entry.
//   Slot alive bits are flip-flops cleared at reset; slot entries and the
//   free stack are RAMs that are read only after they are written, so no
//   clearing pass is needed and the block accepts items right after reset.
//   Reset (rst_n low, synchronous) empties the table and sets the
//   generation counter to 1; the counter skips 0 when it wraps.
module generational_handle_table
  import ght_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ght_in_t  in_item,
  output logic     out_valid,
  output ght_out_t out_item
);

  seq_state_t       state_r, state_nxt;
  ght_in_t          req_r;
  logic [CNT_W-1:0] free_count_r, free_count_nxt;
  logic [CNT_W-1:0] used_slots_r, used_slots_nxt;
  logic [TAG_W-1:0] next_tag_r, next_tag_nxt;
  logic [SLOT_COUNT-1:0] alive_r, alive_nxt;
  logic             out_valid_r, out_valid_nxt;
  ght_out_t         out_item_r, out_item_nxt;

  logic               accept;
  logic [SLOT_AW-1:0] in_idx;
  logic [SLOT_AW-1:0] req_idx;
  logic [ENTRY_W-1:0] slot_rd;
  logic [SLOT_AW-1:0] stack_rd;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_wa;
  logic [ENTRY_W-1:0] slot_wd;
  logic               stack_we;
  logic [TAG_W-1:0]   tag_inc;
  logic               have_free;
  logic               full;
  logic               match;
  logic [SLOT_AW-1:0] new_slot;
  logic [7:0]         clipped_idx;
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic [TAG_W-1:0]   rd_tag;

  assign accept  = start && (state_r == SEQ_IDLE);
  assign in_idx  = in_item.handle_index[SLOT_AW-1:0];
  assign req_idx = req_r.handle_index[SLOT_AW-1:0];

  // Split the slot entry into payload and tag
  assign rd_payload = slot_rd[ENTRY_W-1:TAG_W];
  assign rd_tag     = slot_rd[TAG_W-1:0];

  // Slot entries: payload and tag side by side
  ght_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_wa),
    .wr_data (slot_wd),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (slot_rd)
  );

  // Free stack: read the top on accept, push on retire
  ght_ram #(
    .WIDTH(SLOT_AW),
    .DEPTH(SLOT_COUNT)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stack_we),
    .wr_addr (free_count_r[SLOT_AW-1:0]),
    .wr_data (req_idx),
    .rd_en   (accept),
    .rd_addr (SLOT_AW'(free_count_r - CNT_W'(1))),
    .rd_data (stack_rd)
  );

  // Decode the request against the data read back
  assign have_free = (free_count_r != '0);
  assign full      = !have_free && (used_slots_r == CNT_W'(SLOT_COUNT));
  assign new_slot  = have_free ? stack_rd : used_slots_r[SLOT_AW-1:0];
  assign match     = (req_r.handle_generation != '0)
                  && (32'(req_r.handle_index) < 32'(used_slots_r))
                  && alive_r[req_idx]
                  && (rd_tag == req_r.handle_generation);
  assign clipped_idx = (req_r.handle_index > 16'd255) ? 8'hFF
                                                      : req_r.handle_index[7:0];
  assign tag_inc   = next_tag_r + TAG_W'(1);

  // Next state, RAM writes and result
  always_comb begin
    state_nxt      = state_r;
    free_count_nxt = free_count_r;
    used_slots_nxt = used_slots_r;
    next_tag_nxt   = next_tag_r;
    alive_nxt      = alive_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    slot_we        = 1'b0;
    slot_wa        = new_slot;
    slot_wd        = {PAYLOAD_BITS'(req_r.payload), next_tag_r};
    stack_we       = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        state_nxt                    = SEQ_IDLE;
        out_valid_nxt                = 1'b1;
        out_item_nxt.status          = STS_INVALID;
        out_item_nxt.slot_index      = clipped_idx;
        out_item_nxt.slot_generation = '0;
        out_item_nxt.found_payload   = '0;
        case (req_r.req_type)
          REQ_REGISTER: begin
            if (full) begin
              out_item_nxt.status     = STS_FULL;
              out_item_nxt.slot_index = '0;
            end else begin
              slot_we = 1'b1;
              alive_nxt[new_slot] = 1'b1;
              if (have_free) begin
                free_count_nxt = free_count_r - CNT_W'(1);
              end else begin
                used_slots_nxt = used_slots_r + CNT_W'(1);
              end
              next_tag_nxt = (tag_inc == '0) ? TAG_W'(1) : tag_inc;
              out_item_nxt.status          = STS_OK;
              out_item_nxt.slot_index      = 8'(new_slot);
              out_item_nxt.slot_generation = next_tag_r;
            end
          end
          REQ_RETIRE: begin
            if (match) begin
              alive_nxt[req_idx] = 1'b0;
              stack_we           = 1'b1;
              free_count_nxt     = free_count_r + CNT_W'(1);
              out_item_nxt.status = STS_OK;
            end
          end
          REQ_RESOLVE: begin
            if (match) begin
              out_item_nxt.status        = STS_OK;
              out_item_nxt.found_payload = 32'(rd_payload);
            end
          end
          default: begin
            out_item_nxt.status = STS_INVALID;
          end
        endcase
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEQ_IDLE;
      free_count_r <= '0;
      used_slots_r <= '0;
      next_tag_r   <= TAG_W'(1);
      alive_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      used_slots_r <= used_slots_nxt;
      next_tag_r   <= next_tag_nxt;
      alive_r      <= alive_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != SEQ_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
